// ===== hw/rtl/cfb_pkg.sv =====
// Shared types, codes and constants of the character framebuffer box drawer.
package cfb_pkg;

  // Field and coordinate widths
  localparam int CHAR_W  = 8;
  localparam int DIM_W   = 7;
  localparam int COORD_W = 11;
  localparam int CFG_W   = 32;

  // Default image capacity
  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;

  // Fill value of every cell after reset
  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h2E;

  // Opcodes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_BOX   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Register indexes
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t row;
    coord_t col;
  } cursor_t;

  typedef struct packed {
    logic              status;
    logic [CHAR_W-1:0] read_char;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CELL,
    ST_READ,
    ST_EDGE,
    ST_SIDE_L,
    ST_SIDE_R,
    ST_DONE
  } state_t;

endpackage

// ===== hw/rtl/cfb_req_if.sv =====
// Request channel: one framebuffer command per transfer.
interface cfb_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic signed [8:0] pos_row;
  logic signed [8:0] pos_col;
  logic [7:0]  box_height;
  logic [7:0]  box_width;
  logic [7:0]  char_value;

  modport source (output valid, opcode, pos_row, pos_col, box_height, box_width, char_value,
                  input ready);
  modport sink (input valid, opcode, pos_row, pos_col, box_height, box_width, char_value,
                output ready);
endinterface

// ===== hw/rtl/cfb_rsp_if.sv =====
// Response channel: one status and read byte per transfer.
interface cfb_rsp_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic [7:0] read_char;

  modport source (output valid, status, read_char, input ready);
  modport sink (input valid, status, read_char, output ready);
endinterface

// ===== hw/rtl/char_framebuffer_box_drawer.sv =====
// Top level: character framebuffer with clipped outline drawing.
//
//   channel  dir  handshake              payload
//   req      in   valid/ready            opcode pos_row pos_col box_height box_width char_value
//   rsp      out  valid/ready            status read_char
//   apb      in   psel/penable/pwrite    paddr pwdata -> image_width (0x0), image_height (0x4)
//
// After reset a clearing pass fills all MAX_WIDTH*MAX_HEIGHT cells with '.', one cell per
// cycle; req is not ready during it, APB writes are taken as ever.
// A write passes through the CELL and DONE states before its result is loaded, a read also
// through READ (registered RAM read). A box walks its clipped top and bottom rows cell by
// cell and its middle rows at both sides: the single RAM port writes one cell per cycle.
// One command is in flight at a time; the result register holds a result while rsp stalls.
module char_framebuffer_box_drawer #(
  parameter int MAX_WIDTH  = cfb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = cfb_pkg::DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  cfb_req_if.sink     req,
  cfb_rsp_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [cfb_pkg::DIM_W-1:0]  image_width, image_height;
  logic [cfb_pkg::DIM_W-1:0]  eff_w, eff_h;
  cfb_pkg::cursor_t           cur;
  logic                       in_img;
  logic [AW-1:0]              cell_addr;
  logic                       ram_we, ram_re;
  logic [AW-1:0]              ram_addr;
  logic [cfb_pkg::CHAR_W-1:0] ram_wdata, ram_rdata;
  logic                       res_free, res_load;
  cfb_pkg::rsp_t              res_data;
  logic                       rsp_valid;
  cfb_pkg::rsp_t              rsp_hold;

  // Register file
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= cfb_pkg::DIM_RESET;
      image_height <= cfb_pkg::DIM_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        cfb_pkg::REG_IMAGE_WIDTH:  image_width  <= pwdata[cfb_pkg::DIM_W-1:0];
        cfb_pkg::REG_IMAGE_HEIGHT: image_height <= pwdata[cfb_pkg::DIM_W-1:0];
        default: image_width <= image_width;
      endcase
    end
  end
  assign prdata = (paddr[2] == cfb_pkg::REG_IMAGE_HEIGHT) ?
                  32'(image_height) : 32'(image_width);

  // Clamp the sizes to 1..MAX
  assign eff_w = (image_width == '0) ? cfb_pkg::DIM_W'(1) :
                 (9'(image_width) > 9'(MAX_WIDTH)) ? cfb_pkg::DIM_W'(MAX_WIDTH) : image_width;
  assign eff_h = (image_height == '0) ? cfb_pkg::DIM_W'(1) :
                 (9'(image_height) > 9'(MAX_HEIGHT)) ? cfb_pkg::DIM_W'(MAX_HEIGHT) :
                 image_height;

  cfb_seq #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .eff_w     (eff_w),
    .eff_h     (eff_h),
    .cur_out   (cur),
    .in_img    (in_img),
    .cell_addr (cell_addr),
    .ram_we    (ram_we),
    .ram_re    (ram_re),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .ram_rdata (ram_rdata),
    .res_free  (res_free),
    .res_load  (res_load),
    .res_data  (res_data)
  );

  cfb_addr_unit #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_addr (
    .cur    (cur),
    .eff_w  (eff_w),
    .eff_h  (eff_h),
    .in_img (in_img),
    .addr   (cell_addr)
  );

  cfb_ram #(.WIDTH(cfb_pkg::CHAR_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Result register: hold until the transfer completes
  assign res_free = !rsp_valid || rsp.ready;
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (res_load) begin
      rsp_hold <= res_data;
    end
  end

  assign rsp.valid     = rsp_valid;
  assign rsp.status    = rsp_hold.status;
  assign rsp.read_char = rsp_hold.read_char;
endmodule

// ===== hw/rtl/cfb_ram.sv =====
// Generic single-port RAM with registered read.
module cfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write or read one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end
endmodule

// ===== hw/rtl/cfb_addr_unit.sv =====
// Shared cell address unit: bounds check and row-major address of one cell.
module cfb_addr_unit #(
  parameter int MAX_WIDTH  = cfb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = cfb_pkg::DEF_MAX_HEIGHT,
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  cfb_pkg::cursor_t          cur,
  input  logic [cfb_pkg::DIM_W-1:0] eff_w,
  input  logic [cfb_pkg::DIM_W-1:0] eff_h,
  output logic                      in_img,
  output logic [AW-1:0]             addr
);
  cfb_pkg::coord_t             w_s;
  cfb_pkg::coord_t             h_s;
  logic [2*cfb_pkg::DIM_W-1:0] prod;
  logic [31:0]                 lin;

  assign w_s = $signed({{(cfb_pkg::COORD_W-cfb_pkg::DIM_W){1'b0}}, eff_w});
  assign h_s = $signed({{(cfb_pkg::COORD_W-cfb_pkg::DIM_W){1'b0}}, eff_h});

  // Check the cell against the image in use
  assign in_img = (cur.row >= cfb_pkg::coord_t'(0)) && (cur.row < h_s) &&
                  (cur.col >= cfb_pkg::coord_t'(0)) && (cur.col < w_s);

  // Form row * width + column
  assign prod = (2*cfb_pkg::DIM_W)'(cur.row[cfb_pkg::DIM_W-1:0]) *
                (2*cfb_pkg::DIM_W)'(eff_w);
  assign lin  = 32'(prod) + 32'(cur.col[cfb_pkg::DIM_W-1:0]);
  assign addr = lin[AW-1:0];
endmodule

// ===== hw/rtl/cfb_seq.sv =====
// Command sequencer: clearing pass, single-cell access and outline walk.
module cfb_seq #(
  parameter int MAX_WIDTH  = cfb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = cfb_pkg::DEF_MAX_HEIGHT,
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                       clk,
  input  logic                       rst,
  cfb_req_if.sink                    req,
  input  logic [cfb_pkg::DIM_W-1:0]  eff_w,
  input  logic [cfb_pkg::DIM_W-1:0]  eff_h,
  output cfb_pkg::cursor_t           cur_out,
  input  logic                       in_img,
  input  logic [AW-1:0]              cell_addr,
  output logic                       ram_we,
  output logic                       ram_re,
  output logic [AW-1:0]              ram_addr,
  output logic [cfb_pkg::CHAR_W-1:0] ram_wdata,
  input  logic [cfb_pkg::CHAR_W-1:0] ram_rdata,
  input  logic                       res_free,
  output logic                       res_load,
  output cfb_pkg::rsp_t              res_data
);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  cfb_pkg::state_t  state, state_next;
  logic [AW-1:0]    clr_cnt, clr_cnt_next;
  logic [1:0]       op, op_next;
  logic [cfb_pkg::CHAR_W-1:0] chr, chr_next;
  cfb_pkg::coord_t  bottom, bottom_next;
  cfb_pkg::coord_t  left, left_next;
  cfb_pkg::coord_t  right, right_next;
  cfb_pkg::coord_t  r1, r1_next;
  cfb_pkg::coord_t  c0, c0_next;
  cfb_pkg::coord_t  c1, c1_next;
  cfb_pkg::cursor_t cur, cur_next;
  cfb_pkg::rsp_t    res, res_next;
  logic             rd_ok, rd_ok_next;

  // Request decode
  cfb_pkg::coord_t in_row, in_col, in_bh, in_bw, in_bottom, in_right;
  cfb_pkg::coord_t in_r0, in_r1, in_c0, in_c1, hmax, wmax, row_inc;
  logic            accept, last_row, next_edge;

  assign accept  = req.valid && req.ready;
  assign in_row  = cfb_pkg::coord_t'(req.pos_row);
  assign in_col  = cfb_pkg::coord_t'(req.pos_col);
  assign in_bh   = $signed({3'b000, req.box_height});
  assign in_bw   = $signed({3'b000, req.box_width});
  assign in_bottom = in_row + in_bh - cfb_pkg::coord_t'(1);
  assign in_right  = in_col + in_bw - cfb_pkg::coord_t'(1);
  assign hmax = $signed({4'b0000, eff_h}) - cfb_pkg::coord_t'(1);
  assign wmax = $signed({4'b0000, eff_w}) - cfb_pkg::coord_t'(1);

  // Clamp the box to the image
  assign in_r0 = (in_row < cfb_pkg::coord_t'(0)) ? cfb_pkg::coord_t'(0) : in_row;
  assign in_r1 = (in_bottom > hmax) ? hmax : in_bottom;
  assign in_c0 = (in_col < cfb_pkg::coord_t'(0)) ? cfb_pkg::coord_t'(0) : in_col;
  assign in_c1 = (in_right > wmax) ? wmax : in_right;

  assign row_inc   = cur.row + cfb_pkg::coord_t'(1);
  assign last_row  = (cur.row == r1);
  assign next_edge = (row_inc == bottom);

  // Next state and datapath registers
  always_comb begin
    state_next   = state;
    clr_cnt_next = clr_cnt;
    op_next      = op;
    chr_next     = chr;
    bottom_next  = bottom;
    left_next    = left;
    right_next   = right;
    r1_next      = r1;
    c0_next      = c0;
    c1_next      = c1;
    cur_next     = cur;
    res_next     = res;
    rd_ok_next   = rd_ok;
    case (state)
      cfb_pkg::ST_CLEAR: begin
        clr_cnt_next = clr_cnt + AW'(1);
        if (clr_cnt == LAST_ADDR) begin
          state_next = cfb_pkg::ST_IDLE;
        end
      end
      cfb_pkg::ST_IDLE: begin
        if (accept) begin
          op_next     = req.opcode;
          chr_next    = req.char_value;
          bottom_next = in_bottom;
          left_next   = in_col;
          right_next  = in_right;
          r1_next     = in_r1;
          c0_next     = in_c0;
          c1_next     = in_c1;
          res_next.status    = 1'b1;
          res_next.read_char = '0;
          cur_next.row = in_row;
          cur_next.col = in_col;
          if (req.opcode == cfb_pkg::OP_WRITE || req.opcode == cfb_pkg::OP_READ) begin
            state_next = cfb_pkg::ST_CELL;
          end else if (req.opcode == cfb_pkg::OP_BOX) begin
            if (req.box_height == 8'd0 || req.box_width == 8'd0) begin
              state_next = cfb_pkg::ST_DONE;
            end else begin
              res_next.status = 1'b0;
              cur_next.row    = in_r0;
              if (in_r0 > in_r1) begin
                state_next = cfb_pkg::ST_DONE;
              end else if (in_r0 == in_row || in_r0 == in_bottom) begin
                cur_next.col = in_c0;
                state_next   = cfb_pkg::ST_EDGE;
              end else begin
                state_next = cfb_pkg::ST_SIDE_L;
              end
            end
          end else begin
            state_next = cfb_pkg::ST_DONE;
          end
        end
      end
      cfb_pkg::ST_CELL: begin
        res_next.status = !in_img;
        rd_ok_next      = in_img;
        state_next = (op == cfb_pkg::OP_READ) ? cfb_pkg::ST_READ : cfb_pkg::ST_DONE;
      end
      cfb_pkg::ST_READ: begin
        res_next.read_char = rd_ok ? ram_rdata : '0;
        state_next         = cfb_pkg::ST_DONE;
      end
      cfb_pkg::ST_EDGE: begin
        if (cur.col >= c1) begin
          if (last_row) begin
            state_next = cfb_pkg::ST_DONE;
          end else begin
            cur_next.row = row_inc;
            cur_next.col = next_edge ? c0 : left;
            state_next   = next_edge ? cfb_pkg::ST_EDGE : cfb_pkg::ST_SIDE_L;
          end
        end else begin
          cur_next.col = cur.col + cfb_pkg::coord_t'(1);
        end
      end
      cfb_pkg::ST_SIDE_L: begin
        cur_next.col = right;
        state_next   = cfb_pkg::ST_SIDE_R;
      end
      cfb_pkg::ST_SIDE_R: begin
        if (last_row) begin
          state_next = cfb_pkg::ST_DONE;
        end else begin
          cur_next.row = row_inc;
          cur_next.col = next_edge ? c0 : left;
          state_next   = next_edge ? cfb_pkg::ST_EDGE : cfb_pkg::ST_SIDE_L;
        end
      end
      cfb_pkg::ST_DONE: begin
        if (res_free) begin
          state_next = cfb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cfb_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs: handshake, memory port and result load
  always_comb begin
    req.ready = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = cell_addr;
    ram_wdata = chr;
    res_load  = 1'b0;
    case (state)
      cfb_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_cnt;
        ram_wdata = cfb_pkg::BLANK_CHAR;
      end
      cfb_pkg::ST_IDLE: begin
        req.ready = 1'b1;
      end
      cfb_pkg::ST_CELL: begin
        ram_we = in_img && (op == cfb_pkg::OP_WRITE);
        ram_re = in_img && (op == cfb_pkg::OP_READ);
      end
      cfb_pkg::ST_EDGE: begin
        ram_we = in_img && (cur.col <= c1);
      end
      cfb_pkg::ST_SIDE_L, cfb_pkg::ST_SIDE_R: begin
        ram_we = in_img;
      end
      cfb_pkg::ST_DONE: begin
        res_load = res_free;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign cur_out  = cur;
  assign res_data = res;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= cfb_pkg::ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state   <= state_next;
      clr_cnt <= clr_cnt_next;
    end
  end

  // Command and cursor registers
  always_ff @(posedge clk) begin
    op     <= op_next;
    chr    <= chr_next;
    bottom <= bottom_next;
    left   <= left_next;
    right  <= right_next;
    r1     <= r1_next;
    c0     <= c0_next;
    c1     <= c1_next;
    cur    <= cur_next;
    res    <= res_next;
    rd_ok  <= rd_ok_next;
  end

  // Checks
  a_reset_blocks: assert property (@(posedge clk) rst |=> !req.ready)
    else $error("request taken right after reset");
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == cfb_pkg::ST_IDLE) |-> !ram_we)
    else $error("memory written while idle");
  a_write_inside: assert property (@(posedge clk) disable iff (rst)
    (ram_we && state != cfb_pkg::ST_CLEAR) |-> in_img)
    else $error("write outside the image");
  a_read_follows_cell: assert property (@(posedge clk) disable iff (rst)
    (state == cfb_pkg::ST_READ) |-> ($past(state) == cfb_pkg::ST_CELL))
    else $error("read data stage without a read issue");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    res_load |-> res_free)
    else $error("result loaded over a pending result");
endmodule

// ===== test/char_framebuffer_box_drawer_tb.sv =====
// Testbench for the character framebuffer box drawer: scoreboard against a framebuffer predictor.
module char_framebuffer_box_drawer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_W = cfb_pkg::DEF_MAX_WIDTH;
  localparam int MAX_H = cfb_pkg::DEF_MAX_HEIGHT;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 50;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef struct packed {
    logic [1:0]        opcode;
    logic signed [8:0] pos_row;
    logic signed [8:0] pos_col;
    logic [7:0]        box_height;
    logic [7:0]        box_width;
    logic [7:0]        char_value;
  } cmd_t;

  typedef enum logic {ROW_CMD, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t     kind;
    cmd_t          cmd;
    logic          typed;
    cfb_pkg::rsp_t want;
    logic          cfg_reg;
    logic [6:0]    cfg_value;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  cfb_req_if req();
  cfb_rsp_if rsp();

  char_framebuffer_box_drawer uut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Predictor state: cell contents and the image size registers
  logic [7:0] frame_cells [0:MAX_W*MAX_H-1];
  logic [6:0] shadow_width;
  logic [6:0] shadow_height;

  cfb_pkg::rsp_t awaited_rsp[$];
  int mismatch_count = 0;
  int cycle_count = 0;
  logic req_burst = 1'b0;
  logic rsp_burst = 1'b0;
  cfb_pkg::rsp_t want_rsp;
  plan_row_t directed_plan[$];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Clamp a size register to the range the block actually uses
  function automatic int usable_dim(logic [6:0] v, int limit);
    if (v < 1) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  function automatic bit in_image(int r, int c, int h, int w);
    return r >= 0 && r < h && c >= 0 && c < w;
  endfunction

  // Apply one command to the predicted framebuffer and return its result
  function automatic cfb_pkg::rsp_t apply_command(cmd_t cmd);
    cfb_pkg::rsp_t res;
    int w, h, row, col, bottom, right, r0, r1, c0, c1;
    w = usable_dim(shadow_width, MAX_W);
    h = usable_dim(shadow_height, MAX_H);
    row = $signed(cmd.pos_row);
    col = $signed(cmd.pos_col);
    res.status = STATUS_FAIL;
    res.read_char = '0;
    case (cmd.opcode)
      cfb_pkg::OP_WRITE: begin
        if (in_image(row, col, h, w)) begin
          frame_cells[row*w + col] = cmd.char_value;
          res.status = STATUS_OK;
        end
      end
      cfb_pkg::OP_BOX: begin
        if (cmd.box_height != 0 && cmd.box_width != 0) begin
          bottom = row + cmd.box_height - 1;
          right = col + cmd.box_width - 1;
          r0 = row < 0 ? 0 : row;
          r1 = bottom > h - 1 ? h - 1 : bottom;
          c0 = col < 0 ? 0 : col;
          c1 = right > w - 1 ? w - 1 : right;
          for (int r = r0; r <= r1; r++) begin
            if (r == row || r == bottom) begin
              for (int c = c0; c <= c1; c++) frame_cells[r*w + c] = cmd.char_value;
            end else begin
              if (in_image(r, col, h, w)) frame_cells[r*w + col] = cmd.char_value;
              if (in_image(r, right, h, w)) frame_cells[r*w + right] = cmd.char_value;
            end
          end
          res.status = STATUS_OK;
        end
      end
      cfb_pkg::OP_READ: begin
        if (in_image(row, col, h, w)) begin
          res.read_char = frame_cells[row*w + col];
          res.status = STATUS_OK;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic plan_row_t cmd_row(logic [1:0] op, int row, int col, int bh, int bw,
                                        int ch);
    plan_row_t p;
    p = '0;
    p.kind = ROW_CMD;
    p.cmd.opcode = op;
    p.cmd.pos_row = row[8:0];
    p.cmd.pos_col = col[8:0];
    p.cmd.box_height = bh[7:0];
    p.cmd.box_width = bw[7:0];
    p.cmd.char_value = ch[7:0];
    return p;
  endfunction

  function automatic plan_row_t checked_row(logic [1:0] op, int row, int col, int bh, int bw,
                                            int ch, logic st, logic [7:0] rd);
    plan_row_t p;
    p = cmd_row(op, row, col, bh, bw, ch);
    p.typed = 1'b1;
    p.want.status = st;
    p.want.read_char = rd;
    return p;
  endfunction

  function automatic plan_row_t cfg_row(logic idx, int value);
    plan_row_t p;
    p = '0;
    p.kind = ROW_CFG;
    p.cfg_reg = idx;
    p.cfg_value = value[6:0];
    return p;
  endfunction

  // Coordinates: mostly inside, often near the corner, sometimes just outside or anywhere
  function automatic logic signed [8:0] pick_coord(int dim);
    int sel, v;
    sel = $urandom_range(0, 9);
    if (sel == 0) v = $urandom_range(0, 511);
    else if (sel <= 2) v = $urandom_range(0, dim + 15) - 8;
    else if (sel <= 5) v = $urandom_range(0, dim - 1);
    else v = $urandom_range(0, (dim < 8 ? dim : 8) - 1);
    return v[8:0];
  endfunction

  function automatic logic [7:0] pick_size();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return 8'd0;
    if (sel <= 2) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(1, 12));
  endfunction

  function automatic cmd_t random_command();
    cmd_t cmd;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 30) cmd.opcode = cfb_pkg::OP_WRITE;
    else if (sel < 50) cmd.opcode = cfb_pkg::OP_BOX;
    else if (sel < 96) cmd.opcode = cfb_pkg::OP_READ;
    else cmd.opcode = OP_UNUSED;
    cmd.pos_row = pick_coord(usable_dim(shadow_height, MAX_H));
    cmd.pos_col = pick_coord(usable_dim(shadow_width, MAX_W));
    cmd.box_height = pick_size();
    cmd.box_width = pick_size();
    cmd.char_value = 8'($urandom_range(0, 255));
    return cmd;
  endfunction

  // Offer one command after a random gap; predict its result on transfer
  task automatic issue_command(cmd_t cmd, logic typed, cfb_pkg::rsp_t typed_rsp);
    int gap;
    cfb_pkg::rsp_t predicted;
    if ($urandom_range(0, 19) == 0) req_burst = !req_burst;
    gap = req_burst ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.opcode <= cmd.opcode;
    req.pos_row <= cmd.pos_row;
    req.pos_col <= cmd.pos_col;
    req.box_height <= cmd.box_height;
    req.box_width <= cmd.box_width;
    req.char_value <= cmd.char_value;
    do @(posedge clk); while (!req.ready);
    predicted = apply_command(cmd);
    awaited_rsp.push_back(typed ? typed_rsp : predicted);
  endtask

  // Drop valid and hold until every awaited result has arrived
  task automatic drain_results();
    req.valid <= 1'b0;
    do @(posedge clk); while (awaited_rsp.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(logic idx, logic [6:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {25'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    if (idx == cfb_pkg::REG_IMAGE_WIDTH) shadow_width = value;
    else shadow_height = value;
    @(posedge clk);
  endtask

  // Cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("char_framebuffer_box_drawer: mismatch");
      $finish;
    end
  end

  // Compare each result transfer with the oldest awaited result
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (awaited_rsp.size() == 0) begin
        $error("result with none awaited: status %0d read_char 0x%02h",
               rsp.status, rsp.read_char);
        mismatch_count++;
      end else begin
        want_rsp = awaited_rsp.pop_front();
        if (rsp.status !== want_rsp.status) begin
          $error("status: expected %0d, got %0d", want_rsp.status, rsp.status);
          mismatch_count++;
        end
        if (rsp.read_char !== want_rsp.read_char) begin
          $error("read_char: expected 0x%02h, got 0x%02h", want_rsp.read_char, rsp.read_char);
          mismatch_count++;
        end
      end
    end
  end

  // Stall the result side for a random count per transfer, with stall-free stretches
  initial begin
    int stall;
    do @(posedge clk); while (rst);
    forever begin
      if ($urandom_range(0, 19) == 0) rsp_burst = !rsp_burst;
      stall = rsp_burst ? 0 : $urandom_range(0, 13);
      if (stall != 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
    end
  end

  initial begin
    logic [6:0] w_val, h_val;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    req.valid <= 1'b0;
    req.opcode <= cfb_pkg::OP_WRITE;
    req.pos_row <= '0;
    req.pos_col <= '0;
    req.box_height <= '0;
    req.box_width <= '0;
    req.char_value <= '0;
    rsp.ready <= 1'b0;
    for (int i = 0; i < MAX_W*MAX_H; i++) frame_cells[i] = cfb_pkg::BLANK_CHAR;
    shadow_width = cfb_pkg::DIM_RESET;
    shadow_height = cfb_pkg::DIM_RESET;

    // Directed stimulus at the reset size, then out-of-range and resized images
    directed_plan.push_back(checked_row(cfb_pkg::OP_READ, 0, 0, 0, 0, 0, STATUS_OK,
                                        cfb_pkg::BLANK_CHAR));
    directed_plan.push_back(checked_row(cfb_pkg::OP_READ, 63, 63, 0, 0, 0, STATUS_OK,
                                        cfb_pkg::BLANK_CHAR));
    directed_plan.push_back(checked_row(cfb_pkg::OP_WRITE, 0, 0, 0, 0, 8'h41, STATUS_OK,
                                        8'h00));
    directed_plan.push_back(cmd_row(cfb_pkg::OP_READ, 0, 0, 0, 0, 0));
    directed_plan.push_back(checked_row(cfb_pkg::OP_WRITE, 63, 63, 255, 255, 8'hFF, STATUS_OK,
                                        8'h00));
    directed_plan.push_back(checked_row(cfb_pkg::OP_WRITE, 64, 0, 0, 0, 8'h00, STATUS_FAIL,
                                        8'h00));
    directed_plan.push_back(checked_row(cfb_pkg::OP_WRITE, -1, 5, 0, 0, 8'h55, STATUS_FAIL,
                                        8'h00));
    directed_plan.push_back(checked_row(cfb_pkg::OP_WRITE, 0, 64, 0, 0, 8'hAA, STATUS_FAIL,
                                        8'h00));
    directed_plan.push_back(checked_row(cfb_pkg::OP_READ, -256, -256, 0, 0, 0, STATUS_FAIL,
                                        8'h00));
    directed_plan.push_back(checked_row(cfb_pkg::OP_READ, 255, 255, 0, 0, 0, STATUS_FAIL,
                                        8'h00));
    directed_plan.push_back(checked_row(cfb_pkg::OP_BOX, 1, 1, 0, 5, 8'h23, STATUS_FAIL,
                                        8'h00));
    directed_plan.push_back(checked_row(cfb_pkg::OP_BOX, 1, 1, 5, 0, 8'h23, STATUS_FAIL,
                                        8'h00));
    directed_plan.push_back(cmd_row(cfb_pkg::OP_BOX, 2, 3, 4, 5, 8'h23));
    directed_plan.push_back(cmd_row(cfb_pkg::OP_READ, 2, 3, 0, 0, 0));
    directed_plan.push_back(cmd_row(cfb_pkg::OP_READ, 3, 4, 0, 0, 0));
    directed_plan.push_back(cmd_row(cfb_pkg::OP_READ, 5, 7, 0, 0, 0));
    directed_plan.push_back(cmd_row(cfb_pkg::OP_BOX, -10, -10, 255, 255, 8'h2A));
    directed_plan.push_back(checked_row(cfb_pkg::OP_BOX, -256, -256, 1, 1, 8'h78, STATUS_OK,
                                        8'h00));
    directed_plan.push_back(cmd_row(cfb_pkg::OP_BOX, 60, 60, 2, 255, 8'h3D));
    directed_plan.push_back(cmd_row(cfb_pkg::OP_READ, 61, 63, 0, 0, 0));
    directed_plan.push_back(checked_row(OP_UNUSED, 0, 0, 1, 1, 8'h01, STATUS_FAIL, 8'h00));
    directed_plan.push_back(cfg_row(cfb_pkg::REG_IMAGE_WIDTH, 0));
    directed_plan.push_back(cfg_row(cfb_pkg::REG_IMAGE_HEIGHT, 127));
    directed_plan.push_back(cmd_row(cfb_pkg::OP_READ, 5, 0, 0, 0, 0));
    directed_plan.push_back(checked_row(cfb_pkg::OP_READ, 0, 1, 0, 0, 0, STATUS_FAIL, 8'h00));
    directed_plan.push_back(cfg_row(cfb_pkg::REG_IMAGE_WIDTH, 127));
    directed_plan.push_back(cfg_row(cfb_pkg::REG_IMAGE_HEIGHT, 0));
    directed_plan.push_back(cmd_row(cfb_pkg::OP_READ, 0, 63, 0, 0, 0));
    directed_plan.push_back(cmd_row(cfb_pkg::OP_WRITE, 0, 62, 0, 0, 8'h7E));
    directed_plan.push_back(cfg_row(cfb_pkg::REG_IMAGE_WIDTH, 64));
    directed_plan.push_back(cfg_row(cfb_pkg::REG_IMAGE_HEIGHT, 64));
    directed_plan.push_back(cmd_row(cfb_pkg::OP_READ, 0, 62, 0, 0, 0));

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_CFG) begin
        drain_results();
        write_register(directed_plan[i].cfg_reg, directed_plan[i].cfg_value);
      end else begin
        issue_command(directed_plan[i].cmd, directed_plan[i].typed, directed_plan[i].want);
      end
    end

    // Random phases, each at its own image size; the first few pin the extremes
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin w_val = 7'd1; h_val = 7'd64; end
        1: begin w_val = 7'd64; h_val = 7'd1; end
        2: begin w_val = 7'd0; h_val = 7'd127; end
        3: begin w_val = 7'd127; h_val = 7'd0; end
        default: begin
          w_val = 7'($urandom_range(1, 64));
          h_val = 7'($urandom_range(1, 64));
        end
      endcase
      drain_results();
      write_register(cfb_pkg::REG_IMAGE_WIDTH, w_val);
      write_register(cfb_pkg::REG_IMAGE_HEIGHT, h_val);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) issue_command(random_command(), 1'b0, '0);
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("char_framebuffer_box_drawer: match");
    end else begin
      $display("char_framebuffer_box_drawer: mismatch");
    end
    $finish;
  end

endmodule
